/* sv/abee_pkg.sv */
package abee_pkg;

	localparam int FIELD_W = 11;
	localparam int ALPHA_W = 8;
	localparam int NUM_SIDES = 4;

	// operation codes of an input request
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		SIDE_TOP = 2'd0,
		SIDE_RIGHT = 2'd1,
		SIDE_BOTTOM = 2'd2,
		SIDE_LEFT = 2'd3
	} side_t;

	typedef logic [FIELD_W-1:0] coord_t;

endpackage

/* sv/alpha_boundary_edge_extract.sv */
// Pipeline: a taken request reads the row memories into stage 1, and its edges then load the
// output register.
// Throughput: the single output register sends one edge per cycle while out_ready is high; an
// occupied pixel sends an edge for each side with an empty neighbor, and an edgeless one
// never enters the output register. Reset: counters and the pipeline clear at once, sizes go
// to 1; row memories are not cleared (no clearing pass), as rows are ignored at row counter zero.
module alpha_boundary_edge_extract #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [abee_pkg::FIELD_W-1:0]  cfg_data,
	// pixel requests
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic [abee_pkg::ALPHA_W-1:0]  alpha,
	// edge results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [abee_pkg::FIELD_W-1:0]  start_x,
	output logic [abee_pkg::FIELD_W-1:0]  start_y,
	output logic [abee_pkg::FIELD_W-1:0]  end_x,
	output logic [abee_pkg::FIELD_W-1:0]  end_y,
	output logic [1:0]                    side,
	output logic                          last_edge
);

	// CW holds a width up to MAX_WIDTH, XW indexes a column, HW holds a row count up to MAX_HEIGHT
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	// ------------------------------------------------------------------
	// Row memories: one bit per column, read data registered into stage 1.
	// middle_mem holds the pending row, older_mem the row above it.
	// ------------------------------------------------------------------
	logic middle_mem [MAX_WIDTH];
	logic older_mem [MAX_WIDTH];

	// configuration, held clamped to the legal range
	logic [CW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CW-1:0] width_clamped;
	logic [HW-1:0] height_clamped;

	// position of the next request
	logic [XW-1:0] column_q;
	logic [HW-1:0] row_q;
	logic          flush_in_row_q;

	// stage 1: memory read data plus request info
	logic          s1_valid_q;
	logic [XW-1:0] col_s1;
	logic [HW-1:0] row_s1;
	logic          below_s1;
	logic          right_ok_s1;
	logic          first_col_s1;
	logic          mid_c_s1;
	logic          mid_n_s1;
	logic          old_c_s1;
	logic          fwd_c_s1;
	logic          fwd_n_s1;
	logic          fwd_below_s1;
	logic          fwd_self_s1;
	logic          self_prev_q;

	// stage 2: output register, one mask bit per edge still to send
	logic [abee_pkg::NUM_SIDES-1:0] mask_s2;
	abee_pkg::coord_t               x0_s2;
	abee_pkg::coord_t               x1_s2;
	abee_pkg::coord_t               y0_s2;
	abee_pkg::coord_t               y1_s2;

	// request decode
	logic          in_fire;
	logic          is_flush;
	logic          is_below;
	logic [31:0]   col_p1;
	logic          last_col;
	logic [XW-1:0] addr_c;
	logic [XW-1:0] addr_n;

	// stage 1 evaluation
	logic                           live;
	logic                           self_occ;
	logic                           top_occ;
	logic                           right_occ;
	logic                           left_occ;
	logic [abee_pkg::NUM_SIDES-1:0] edge_mask;
	logic                           s1_go;
	logic                           out_fire;
	logic                           s2_done;
	logic [31:0]                    y_top;

	abee_pkg::side_t cur_side;

	function automatic abee_pkg::coord_t col_p1_s1_trunc(input logic [XW-1:0] c);
		logic [31:0] sum;
		sum = 32'(c) + 32'd1;
		return sum[abee_pkg::FIELD_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Clamp register writes to 1..MAX
	// ------------------------------------------------------------------
	always_comb begin
		if (cfg_data == '0) begin
			width_clamped = CW'(1);
			height_clamped = HW'(1);
		end else begin
			width_clamped = (32'(cfg_data) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(cfg_data);
			height_clamped = (32'(cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
		end
	end

	// ------------------------------------------------------------------
	// Request decode. A pixel past the last row counts as flush, and a
	// flush is stored as empty below.
	// ------------------------------------------------------------------
	assign in_fire = in_valid && in_ready;
	assign is_flush = (operation == abee_pkg::OP_FLUSH) || (row_q >= height_q);
	assign is_below = !is_flush && (alpha != '0);
	assign col_p1 = 32'(column_q) + 32'd1;
	assign last_col = col_p1 >= 32'(width_q);
	assign addr_c = column_q;
	assign addr_n = XW'(col_p1);

	// ------------------------------------------------------------------
	// Stage 1: occupancy of the pixel in the pending row and its
	// neighbors. Row memories mean nothing while the row counter is zero
	// (nothing has been written in this image yet), so gate them off.
	// A write by the request just ahead lands on the edge that issued our
	// read; take its value from the forwarding registers instead.
	// ------------------------------------------------------------------
	assign live = row_s1 != '0;
	assign self_occ = live && (fwd_c_s1 ? fwd_below_s1 : mid_c_s1);
	assign top_occ = live && (fwd_c_s1 ? fwd_self_s1 : old_c_s1);
	assign right_occ = live && right_ok_s1 && (fwd_n_s1 ? fwd_below_s1 : mid_n_s1);
	// self_prev_q holds the previous pixel of this row (also written to the older row at column-1)
	assign left_occ = !first_col_s1 && self_prev_q;

	always_comb begin
		edge_mask = '0;
		if (self_occ) begin
			edge_mask[abee_pkg::SIDE_TOP] = !top_occ;
			edge_mask[abee_pkg::SIDE_RIGHT] = !right_occ;
			edge_mask[abee_pkg::SIDE_BOTTOM] = !below_s1;
			edge_mask[abee_pkg::SIDE_LEFT] = !left_occ;
		end
	end

	assign out_fire = out_valid && out_ready;
	assign s2_done = out_fire && last_edge;
	// an edgeless request never needs the output register
	assign s1_go = s1_valid_q && ((edge_mask == '0) || (mask_s2 == '0) || s2_done);
	assign in_ready = !s1_valid_q || s1_go;
	assign y_top = 32'(row_s1) - 32'd1;

	// ------------------------------------------------------------------
	// Memory ports: read on request, write back when stage 1 advances
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			mid_c_s1 <= middle_mem[addr_c];
			mid_n_s1 <= middle_mem[addr_n];
			old_c_s1 <= older_mem[addr_c];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			middle_mem[col_s1] <= below_s1;
			older_mem[col_s1] <= self_occ;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 payload, including forwarding from the request ahead.
	// Taking a request while stage 1 is full means that one leaves and
	// writes on this very edge.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1 <= column_q;
			row_s1 <= row_q;
			below_s1 <= is_below;
			right_ok_s1 <= !last_col;
			first_col_s1 <= column_q == '0;
			fwd_c_s1 <= s1_valid_q && (addr_c == col_s1);
			fwd_n_s1 <= s1_valid_q && (addr_n == col_s1);
			fwd_below_s1 <= below_s1;
			fwd_self_s1 <= self_occ;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2 payload: corner coordinates of the pixel
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s1_go && (edge_mask != '0)) begin
			x0_s2 <= abee_pkg::coord_t'(col_s1);
			x1_s2 <= col_p1_s1_trunc(col_s1);
			y0_s2 <= y_top[abee_pkg::FIELD_W-1:0];
			y1_s2 <= abee_pkg::coord_t'(row_s1);
		end
	end

	// ------------------------------------------------------------------
	// Control: configuration, counters, stage valids
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CW'(1);
			height_q <= HW'(1);
			column_q <= '0;
			row_q <= '0;
			flush_in_row_q <= 1'b0;
			s1_valid_q <= 1'b0;
			self_prev_q <= 1'b0;
			mask_s2 <= '0;
		end else begin
			if (cfg_write) begin
				// any write aborts the image in progress
				if (cfg_index == abee_pkg::REG_IMAGE_WIDTH) begin
					width_q <= width_clamped;
				end else begin
					height_q <= height_clamped;
				end
				column_q <= '0;
				row_q <= '0;
				flush_in_row_q <= 1'b0;
			end else if (in_fire) begin
				if (last_col) begin
					column_q <= '0;
					if (flush_in_row_q || is_flush) begin
						// end of image: start over
						row_q <= '0;
						flush_in_row_q <= 1'b0;
					end else begin
						row_q <= HW'(32'(row_q) + 32'd1);
					end
				end else begin
					column_q <= addr_n;
					flush_in_row_q <= flush_in_row_q || is_flush;
				end
			end

			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end

			if (s1_go) begin
				self_prev_q <= self_occ;
			end

			// load a new edge set, or drop the edge just sent
			if (s1_go && (edge_mask != '0)) begin
				mask_s2 <= edge_mask;
			end else if (out_fire) begin
				mask_s2 <= mask_s2 & (mask_s2 - {{(abee_pkg::NUM_SIDES-1){1'b0}}, 1'b1});
			end
		end
	end

	// ------------------------------------------------------------------
	// Output: send edges in order top, right, bottom, left
	// ------------------------------------------------------------------
	always_comb begin
		if (mask_s2[abee_pkg::SIDE_TOP]) begin
			cur_side = abee_pkg::SIDE_TOP;
		end else if (mask_s2[abee_pkg::SIDE_RIGHT]) begin
			cur_side = abee_pkg::SIDE_RIGHT;
		end else if (mask_s2[abee_pkg::SIDE_BOTTOM]) begin
			cur_side = abee_pkg::SIDE_BOTTOM;
		end else begin
			cur_side = abee_pkg::SIDE_LEFT;
		end
	end

	always_comb begin
		case (cur_side)
			abee_pkg::SIDE_TOP: begin
				start_x = x1_s2;
				start_y = y0_s2;
				end_x = x0_s2;
				end_y = y0_s2;
			end
			abee_pkg::SIDE_RIGHT: begin
				start_x = x1_s2;
				start_y = y1_s2;
				end_x = x1_s2;
				end_y = y0_s2;
			end
			abee_pkg::SIDE_BOTTOM: begin
				start_x = x0_s2;
				start_y = y1_s2;
				end_x = x1_s2;
				end_y = y1_s2;
			end
			default: begin
				start_x = x0_s2;
				start_y = y0_s2;
				end_x = x0_s2;
				end_y = y1_s2;
			end
		endcase
	end

	assign out_valid = mask_s2 != '0;
	assign side = cur_side;
	assign last_edge = $countones(mask_s2) == 1;

`ifndef ASSERT_OFF
	a_column_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		32'(column_q) < 32'(width_q))
		else $error("column counter beyond image width");

	a_row_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= height_q)
		else $error("row counter beyond image height");

	a_more_edges: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !last_edge) |=> (out_valid && $stable(x0_s2) && $stable(y0_s2)))
		else $error("edge set of a pixel cut short");

	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> (column_q == '0 && row_q == '0 && !flush_in_row_q))
		else $error("register write did not restart the image");
`endif

endmodule
